FILE: src/arlt_pkg.sv
// Shared types, constants and register map of the restart limit tuner.
package arlt_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int EXT_W          = 64;
    localparam int FIELD_TICK_W   = 32;
    localparam int ACC_W          = 32;
    localparam int ACC_SUM_W      = EXT_W + 1;
    localparam int PROD_W         = 39;
    localparam int QUOT_BITS      = 10;
    localparam int DIV_A_W        = PROD_W - QUOT_BITS;
    localparam int WIN_W          = 16;
    localparam int PCT_W          = 8;
    localparam int CNT_W          = 4;
    localparam int LIMIT_W        = 8;
    localparam int USAGE_W        = 10;
    localparam int RES_W          = 4;
    localparam int STEP_W         = 4;

    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int S_TDATA_W      = 72;
    localparam int M_TDATA_W      = 24;

    localparam logic [WIN_W-1:0]   WINDOW_RST    = 16'd10;
    localparam logic [WIN_W-1:0]   INTERVAL_RST  = 16'd20;
    localparam logic [PCT_W-1:0]   PEAK_LOAD_RST = 8'd110;
    localparam logic [PCT_W-1:0]   LOAD_GAP_RST  = 8'd20;
    localparam logic [LIMIT_W-1:0] MAX_RST_RST   = 8'd10;
    localparam logic [CNT_W-1:0]   HIGH_LIM_RST  = 4'd6;
    localparam logic [CNT_W-1:0]   LOW_LIM_RST   = 4'd6;
    localparam logic [USAGE_W-1:0] USAGE_SAT     = 10'd1023;

    localparam logic [2:0] REG_WINDOW_TICKS   = 3'd0;
    localparam logic [2:0] REG_COUNT_INTERVAL = 3'd1;
    localparam logic [2:0] REG_PEAK_LOAD      = 3'd2;
    localparam logic [2:0] REG_LOAD_GAP       = 3'd3;
    localparam logic [2:0] REG_MAX_RESTART    = 3'd4;
    localparam logic [2:0] REG_HIGH_LIMIT     = 3'd5;
    localparam logic [2:0] REG_LOW_LIMIT      = 3'd6;

    localparam logic OP_BUSY = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_LOW,
        CNT_HIGH
    } t_count_kind;

    typedef struct packed {
        logic [CNT_W-1:0]   high;
        logic [CNT_W-1:0]   low;
        logic [LIMIT_W-1:0] limit;
    } t_win_cnt;

    typedef struct packed {
        logic s_tready;
        logic m_tvalid;
        logic sel_div;
    } t_ctrl;

endpackage

FILE: src/adaptive_restart_limit_tuner_core.sv
// Top level of the restart limit tuner: sequencer, window state and register port.
// An idle event or a busy pass that does not close a window goes from accumulate to
// output. A closing pass multiplies, checks for saturation, runs 10 divider steps
// unless usage saturates, and updates; the shared subtract unit serves the check and
// the divider steps. A new input is taken only after the previous result transfer.
// Synchronous active-low reset restores configuration, window and sequencer state only.
module adaptive_restart_limit_tuner_core #(
    parameter int TICK_WIDTH = arlt_pkg::TICK_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // now_tick [31:0], start_tick [63:32], load_reserved [67:64]
    input  logic [arlt_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // opcode [0]
    input  logic                            i_s_tuser,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // restart_limit [7:0], usage_percent [17:8]
    output logic [arlt_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // window_closed [0]
    output logic                            o_m_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arlt_pkg::ADDR_W-1:0]     paddr,
    input  logic [arlt_pkg::DATA_W-1:0]     pwdata,
    output logic [arlt_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    arlt_pkg::t_state   r_state, n_state;
    arlt_pkg::t_ctrl    w_ctrl;

    logic [arlt_pkg::WIN_W-1:0]   r_window_ticks;
    logic [arlt_pkg::WIN_W-1:0]   r_interval;
    logic [arlt_pkg::PCT_W-1:0]   r_peak_load;
    logic [arlt_pkg::PCT_W-1:0]   r_load_gap;
    logic [arlt_pkg::LIMIT_W-1:0] r_max_restart;
    logic [arlt_pkg::CNT_W-1:0]   r_high_lim;
    logic [arlt_pkg::CNT_W-1:0]   r_low_lim;

    logic                          r_op;
    logic [TICK_WIDTH-1:0]         r_now;
    logic [TICK_WIDTH-1:0]         r_start;
    logic [arlt_pkg::RES_W-1:0]    r_reserved;

    logic [arlt_pkg::ACC_W-1:0]    r_accum;
    logic [TICK_WIDTH-1:0]         r_window_deadline;
    logic [TICK_WIDTH-1:0]         r_count_deadline;
    arlt_pkg::t_win_cnt            r_cnt;
    logic [arlt_pkg::USAGE_W-1:0]  r_usage;
    logic                          r_closed;

    logic [arlt_pkg::PROD_W-1:0]    r_prod;
    logic [arlt_pkg::WIN_W-1:0]     r_rem;
    logic [arlt_pkg::QUOT_BITS-1:0] r_quot;
    logic [arlt_pkg::STEP_W-1:0]    r_step;

    logic [arlt_pkg::EXT_W-1:0]     w_now_ext;
    logic [arlt_pkg::EXT_W-1:0]     w_start_ext;
    logic [TICK_WIDTH-1:0]          w_busy;
    logic [arlt_pkg::ACC_SUM_W-1:0] w_sum;
    logic [arlt_pkg::ACC_W-1:0]     w_acc_next;
    logic [TICK_WIDTH-1:0]          w_win_diff;
    logic                           w_win_due;
    logic [arlt_pkg::PROD_W-1:0]    w_prod;
    logic [arlt_pkg::WIN_W-1:0]     w_divisor;
    logic [arlt_pkg::DIV_A_W-1:0]   w_sub_a;
    logic                           w_sub_ge;
    logic [arlt_pkg::DIV_A_W-1:0]   w_sub_diff;
    logic [arlt_pkg::PCT_W-1:0]     w_high_th;
    logic [arlt_pkg::PCT_W-1:0]     w_low_base;
    logic [arlt_pkg::PCT_W-1:0]     w_low_th;
    arlt_pkg::t_count_kind          w_kind;
    arlt_pkg::t_win_cnt             w_cnt_upd;
    logic [TICK_WIDTH-1:0]          w_deadline_upd;
    logic                           w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= arlt_pkg::WINDOW_RST;
            r_interval     <= arlt_pkg::INTERVAL_RST;
            r_peak_load    <= arlt_pkg::PEAK_LOAD_RST;
            r_load_gap     <= arlt_pkg::LOAD_GAP_RST;
            r_max_restart  <= arlt_pkg::MAX_RST_RST;
            r_high_lim     <= arlt_pkg::HIGH_LIM_RST;
            r_low_lim      <= arlt_pkg::LOW_LIM_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                arlt_pkg::REG_WINDOW_TICKS:   r_window_ticks <= pwdata[15:0];
                arlt_pkg::REG_COUNT_INTERVAL: r_interval     <= pwdata[15:0];
                arlt_pkg::REG_PEAK_LOAD:      r_peak_load    <= pwdata[7:0];
                arlt_pkg::REG_LOAD_GAP:       r_load_gap     <= pwdata[7:0];
                arlt_pkg::REG_MAX_RESTART:    r_max_restart  <= pwdata[7:0];
                arlt_pkg::REG_HIGH_LIMIT:     r_high_lim     <= pwdata[3:0];
                arlt_pkg::REG_LOW_LIMIT:      r_low_lim      <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            arlt_pkg::REG_WINDOW_TICKS:   prdata = 32'(r_window_ticks);
            arlt_pkg::REG_COUNT_INTERVAL: prdata = 32'(r_interval);
            arlt_pkg::REG_PEAK_LOAD:      prdata = 32'(r_peak_load);
            arlt_pkg::REG_LOAD_GAP:       prdata = 32'(r_load_gap);
            arlt_pkg::REG_MAX_RESTART:    prdata = 32'(r_max_restart);
            arlt_pkg::REG_HIGH_LIMIT:     prdata = 32'(r_high_lim);
            arlt_pkg::REG_LOW_LIMIT:      prdata = 32'(r_low_lim);
            default:                      prdata = '0;
        endcase
    end

    assign w_now_ext   = arlt_pkg::EXT_W'(i_s_tdata[31:0]);
    assign w_start_ext = arlt_pkg::EXT_W'(i_s_tdata[63:32]);

    assign w_busy     = r_now - r_start;
    assign w_sum      = arlt_pkg::ACC_SUM_W'(r_accum) + arlt_pkg::ACC_SUM_W'(w_busy);
    assign w_acc_next = (w_sum[arlt_pkg::ACC_SUM_W-1:arlt_pkg::ACC_W] != '0) ? '1 :
                        w_sum[arlt_pkg::ACC_W-1:0];

    assign w_win_diff = r_now - r_window_deadline;
    assign w_win_due  = (w_win_diff != '0) && !w_win_diff[TICK_WIDTH-1];

    assign w_prod = (arlt_pkg::PROD_W'(r_accum) << 6) + (arlt_pkg::PROD_W'(r_accum) << 5) +
                    (arlt_pkg::PROD_W'(r_accum) << 2);

    assign w_divisor = (r_window_ticks == '0) ? 16'd1 : r_window_ticks;
    assign w_sub_a   = w_ctrl.sel_div ?
                       arlt_pkg::DIV_A_W'({r_rem, r_prod[arlt_pkg::QUOT_BITS-1]}) :
                       r_prod[arlt_pkg::PROD_W-1:arlt_pkg::QUOT_BITS];

    arlt_sub_unit u_sub (
        .i_a    (w_sub_a),
        .i_b    (w_divisor),
        .o_ge   (w_sub_ge),
        .o_diff (w_sub_diff)
    );

    assign w_high_th  = (r_peak_load > 8'(r_reserved)) ? r_peak_load - 8'(r_reserved) : '0;
    assign w_low_base = (r_peak_load > r_load_gap) ? r_peak_load - r_load_gap : '0;
    assign w_low_th   = (w_low_base > 8'(r_reserved)) ? w_low_base - 8'(r_reserved) : '0;

    always_comb begin
        w_kind = arlt_pkg::CNT_NONE;
        if (r_state == arlt_pkg::ST_ACCUM) begin
            if (r_op == arlt_pkg::OP_IDLE) begin
                w_kind = arlt_pkg::CNT_LOW;
            end
        end else if (r_quot >= 10'(w_high_th)) begin
            w_kind = arlt_pkg::CNT_HIGH;
        end else if (r_quot < 10'(w_low_th)) begin
            w_kind = arlt_pkg::CNT_LOW;
        end
    end

    arlt_limit_update #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_limit (
        .i_kind        (w_kind),
        .i_cnt         (r_cnt),
        .i_now         (r_now),
        .i_deadline    (r_count_deadline),
        .i_interval    (r_interval),
        .i_high_lim    (r_high_lim),
        .i_low_lim     (r_low_lim),
        .i_max_restart (r_max_restart),
        .o_cnt         (w_cnt_upd),
        .o_deadline    (w_deadline_upd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arlt_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = arlt_pkg::ST_ACCUM;
                end
            end
            arlt_pkg::ST_ACCUM: begin
                if (r_op == arlt_pkg::OP_BUSY && w_win_due) begin
                    n_state = arlt_pkg::ST_MUL;
                end else begin
                    n_state = arlt_pkg::ST_OUT;
                end
            end
            arlt_pkg::ST_MUL:    n_state = arlt_pkg::ST_CHECK;
            arlt_pkg::ST_CHECK: begin
                n_state = w_sub_ge ? arlt_pkg::ST_UPDATE : arlt_pkg::ST_DIV;
            end
            arlt_pkg::ST_DIV: begin
                if (r_step == 4'(arlt_pkg::QUOT_BITS - 1)) begin
                    n_state = arlt_pkg::ST_UPDATE;
                end
            end
            arlt_pkg::ST_UPDATE: n_state = arlt_pkg::ST_OUT;
            arlt_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = arlt_pkg::ST_IDLE;
                end
            end
            default: n_state = arlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            arlt_pkg::ST_IDLE: w_ctrl.s_tready = 1'b1;
            arlt_pkg::ST_DIV:  w_ctrl.sel_div  = 1'b1;
            arlt_pkg::ST_OUT:  w_ctrl.m_tvalid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arlt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum           <= '0;
            r_window_deadline <= '0;
            r_count_deadline  <= '0;
            r_cnt.high        <= '0;
            r_cnt.low         <= '0;
            r_cnt.limit       <= arlt_pkg::MAX_RST_RST;
            r_usage           <= '0;
            r_closed          <= 1'b0;
        end else begin
            unique case (r_state)
                arlt_pkg::ST_ACCUM: begin
                    r_closed <= 1'b0;
                    if (r_op == arlt_pkg::OP_IDLE) begin
                        r_cnt             <= w_cnt_upd;
                        r_count_deadline  <= w_deadline_upd;
                        r_window_deadline <= r_now + TICK_WIDTH'(r_window_ticks);
                        r_accum           <= '0;
                    end else begin
                        r_accum <= w_acc_next;
                    end
                end
                arlt_pkg::ST_UPDATE: begin
                    r_usage           <= r_quot;
                    r_cnt             <= w_cnt_upd;
                    r_count_deadline  <= w_deadline_upd;
                    r_window_deadline <= r_now + TICK_WIDTH'(r_window_ticks);
                    r_accum           <= '0;
                    r_closed          <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            arlt_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    r_op       <= i_s_tuser;
                    r_now      <= w_now_ext[TICK_WIDTH-1:0];
                    r_start    <= w_start_ext[TICK_WIDTH-1:0];
                    r_reserved <= i_s_tdata[67:64];
                end
            end
            arlt_pkg::ST_MUL: r_prod <= w_prod;
            arlt_pkg::ST_CHECK: begin
                r_step <= '0;
                if (w_sub_ge) begin
                    r_quot <= arlt_pkg::USAGE_SAT;
                end else begin
                    r_rem <= r_prod[25:10];
                end
            end
            arlt_pkg::ST_DIV: begin
                r_rem  <= w_sub_ge ? w_sub_diff[15:0] : w_sub_a[15:0];
                r_quot <= {r_quot[arlt_pkg::QUOT_BITS-2:0], w_sub_ge};
                r_prod <= r_prod << 1;
                r_step <= r_step + 4'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_s_tready = w_ctrl.s_tready;
    assign o_m_tvalid = w_ctrl.m_tvalid;
    assign o_m_tdata  = {6'd0, r_usage, r_cnt.limit};
    assign o_m_tuser  = r_closed;

endmodule

FILE: src/arlt_sub_unit.sv
// Shared compare and subtract unit used by the saturation check and the divider steps.
module arlt_sub_unit (
    input  logic [arlt_pkg::DIV_A_W-1:0] i_a,
    input  logic [arlt_pkg::WIN_W-1:0]   i_b,
    output logic                         o_ge,
    output logic [arlt_pkg::DIV_A_W-1:0] o_diff
);

    logic [arlt_pkg::DIV_A_W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - (arlt_pkg::DIV_A_W + 1)'(i_b);
    assign o_ge   = ~w_sub[arlt_pkg::DIV_A_W];
    assign o_diff = w_sub[arlt_pkg::DIV_A_W-1:0];

endmodule

FILE: src/arlt_limit_update.sv
// High and low window counting with rate limit, and the restart limit adjustment.
module arlt_limit_update #(
    parameter int TICK_WIDTH = arlt_pkg::TICK_WIDTH_DEF
) (
    input  arlt_pkg::t_count_kind            i_kind,
    input  arlt_pkg::t_win_cnt               i_cnt,
    input  logic [TICK_WIDTH-1:0]            i_now,
    input  logic [TICK_WIDTH-1:0]            i_deadline,
    input  logic [arlt_pkg::WIN_W-1:0]       i_interval,
    input  logic [arlt_pkg::CNT_W-1:0]       i_high_lim,
    input  logic [arlt_pkg::CNT_W-1:0]       i_low_lim,
    input  logic [arlt_pkg::LIMIT_W-1:0]     i_max_restart,
    output arlt_pkg::t_win_cnt               o_cnt,
    output logic [TICK_WIDTH-1:0]            o_deadline
);

    logic [TICK_WIDTH-1:0] w_diff;
    logic                  w_fire;

    assign w_diff = i_now - i_deadline;
    assign w_fire = (w_diff != '0) && !w_diff[TICK_WIDTH-1];

    always_comb begin
        o_cnt      = i_cnt;
        o_deadline = i_deadline;
        case (i_kind)
            arlt_pkg::CNT_LOW: begin
                o_cnt.high = '0;
                if (w_fire) begin
                    o_cnt.low  = i_cnt.low + 4'd1;
                    o_deadline = i_now + TICK_WIDTH'(i_interval);
                end
                if (o_cnt.low >= i_low_lim) begin
                    o_cnt.low = '0;
                    if (i_cnt.limit < i_max_restart) begin
                        o_cnt.limit = i_cnt.limit + 8'd1;
                    end
                end
            end
            arlt_pkg::CNT_HIGH: begin
                o_cnt.low = '0;
                if (w_fire) begin
                    o_cnt.high = i_cnt.high + 4'd1;
                    o_deadline = i_now + TICK_WIDTH'(i_interval);
                end
                if (o_cnt.high >= i_high_lim) begin
                    o_cnt.high = '0;
                    if (i_cnt.limit > 8'd1) begin
                        o_cnt.limit = i_cnt.limit >> 1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/arlt_checker.sv
// Port-level assertions for the restart limit tuner and their binding to the top level.
module arlt_port_checks (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           i_s_tready,
    input logic [arlt_pkg::M_TDATA_W-1:0] i_m_tdata,
    input logic                           i_m_tuser,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready
);

    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_s_tready && i_m_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> (!i_s_tready && !i_m_tvalid))
        else $error("accepted transfer did not start a computation");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
        (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

    a_limit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[7:0] != 8'd0))
        else $error("restart limit reached zero");

endmodule

bind adaptive_restart_limit_tuner_core arlt_port_checks u_arlt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

FILE: tb/arlt_checker.sv
// Checker for the restart limit tuner: tracks registers, predicts each result and compares.
module arlt_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [arlt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [arlt_pkg::M_TDATA_W-1:0]   i_m_tdata,
    input  logic                             i_m_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [arlt_pkg::ADDR_W-1:0]      paddr,
    input  logic [arlt_pkg::DATA_W-1:0]      pwdata,
    input  logic                             pready,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic [arlt_pkg::LIMIT_W-1:0] limit;
        logic [arlt_pkg::USAGE_W-1:0] usage;
        logic                         closed;
    } t_tuner_result;

    logic [arlt_pkg::WIN_W-1:0]   cfg_window;
    logic [arlt_pkg::WIN_W-1:0]   cfg_interval;
    logic [arlt_pkg::PCT_W-1:0]   cfg_peak_load;
    logic [arlt_pkg::PCT_W-1:0]   cfg_load_gap;
    logic [arlt_pkg::LIMIT_W-1:0] cfg_max_restart;
    logic [arlt_pkg::CNT_W-1:0]   cfg_high_limit;
    logic [arlt_pkg::CNT_W-1:0]   cfg_low_limit;

    logic [arlt_pkg::ACC_W-1:0]   busy_sum;
    logic [31:0]                  window_end;
    logic [31:0]                  count_end;
    logic [arlt_pkg::CNT_W-1:0]   high_wins;
    logic [arlt_pkg::CNT_W-1:0]   low_wins;
    logic [arlt_pkg::LIMIT_W-1:0] restart_limit;
    logic [arlt_pkg::USAGE_W-1:0] last_usage;

    t_tuner_result      limit_q[$];
    int                 fail_count = 0;
    int                 result_index = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = limit_q.size();

    function automatic logic tick_is_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic void note_low_window(logic [31:0] now);
        high_wins = '0;
        if (tick_is_after(now, count_end)) begin
            low_wins  = low_wins + 4'd1;
            count_end = now + {16'd0, cfg_interval};
        end
        if (low_wins >= cfg_low_limit) begin
            low_wins = '0;
            if (restart_limit < cfg_max_restart) begin
                restart_limit = restart_limit + 8'd1;
            end
        end
    endfunction

    function automatic void note_high_window(logic [31:0] now);
        low_wins = '0;
        if (tick_is_after(now, count_end)) begin
            high_wins = high_wins + 4'd1;
            count_end = now + {16'd0, cfg_interval};
        end
        if (high_wins >= cfg_high_limit) begin
            high_wins = '0;
            if (restart_limit > 8'd1) begin
                restart_limit = restart_limit >> 1;
            end
        end
    endfunction

    function automatic t_tuner_result tune_step(logic op, logic [31:0] now, logic [31:0] start,
                                                logic [arlt_pkg::RES_W-1:0] rsv);
        t_tuner_result r;
        logic [31:0]   busy;
        logic [32:0]   sum;
        logic [38:0]   quot;
        logic [15:0]   div;
        int            high_th;
        int            low_base;
        int            low_th;
        r.closed = 1'b0;
        if (op == arlt_pkg::OP_IDLE) begin
            note_low_window(now);
            window_end = now + {16'd0, cfg_window};
            busy_sum   = '0;
        end else begin
            busy     = now - start;
            sum      = {1'b0, busy_sum} + {1'b0, busy};
            busy_sum = sum[32] ? '1 : sum[31:0];
            if (tick_is_after(now, window_end)) begin
                div        = (cfg_window == '0) ? 16'd1 : cfg_window;
                quot       = (39'(busy_sum) * 39'd100) / 39'(div);
                last_usage = (quot > 39'd1023) ? arlt_pkg::USAGE_SAT :
                             quot[arlt_pkg::USAGE_W-1:0];
                high_th    = (int'(cfg_peak_load) > int'(rsv)) ?
                             int'(cfg_peak_load) - int'(rsv) : 0;
                low_base   = (cfg_peak_load > cfg_load_gap) ?
                             int'(cfg_peak_load) - int'(cfg_load_gap) : 0;
                low_th     = (low_base > int'(rsv)) ? low_base - int'(rsv) : 0;
                if (int'(last_usage) >= high_th) begin
                    note_high_window(now);
                end else if (int'(last_usage) < low_th) begin
                    note_low_window(now);
                end
                window_end = now + {16'd0, cfg_window};
                busy_sum   = '0;
                r.closed   = 1'b1;
            end
        end
        r.limit = restart_limit;
        r.usage = last_usage;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tuner_result got;
        t_tuner_result want;
        if (!i_rst_n) begin
            cfg_window      = arlt_pkg::WINDOW_RST;
            cfg_interval    = arlt_pkg::INTERVAL_RST;
            cfg_peak_load   = arlt_pkg::PEAK_LOAD_RST;
            cfg_load_gap    = arlt_pkg::LOAD_GAP_RST;
            cfg_max_restart = arlt_pkg::MAX_RST_RST;
            cfg_high_limit  = arlt_pkg::HIGH_LIM_RST;
            cfg_low_limit   = arlt_pkg::LOW_LIM_RST;
            busy_sum        = '0;
            window_end      = '0;
            count_end       = '0;
            high_wins       = '0;
            low_wins        = '0;
            restart_limit   = arlt_pkg::MAX_RST_RST;
            last_usage      = '0;
            limit_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.limit  = i_m_tdata[7:0];
                got.usage  = i_m_tdata[17:8];
                got.closed = i_m_tuser;
                if (limit_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result %0d unexpected: limit %0d usage %0d closed %0d",
                                 result_index, got.limit, got.usage, got.closed);
                    end
                end else begin
                    want = limit_q.pop_front();
                    if (got.limit !== want.limit || got.usage !== want.usage ||
                        got.closed !== want.closed) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     result_index, want.limit, want.usage, want.closed,
                                     got.limit, got.usage, got.closed);
                        end
                    end
                end
                result_index++;
            end
            if (i_s_tvalid && i_s_tready) begin
                limit_q.push_back(tune_step(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32],
                                            i_s_tdata[67:64]));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    arlt_pkg::REG_WINDOW_TICKS:
                        cfg_window      = pwdata[arlt_pkg::WIN_W-1:0];
                    arlt_pkg::REG_COUNT_INTERVAL:
                        cfg_interval    = pwdata[arlt_pkg::WIN_W-1:0];
                    arlt_pkg::REG_PEAK_LOAD:
                        cfg_peak_load   = pwdata[arlt_pkg::PCT_W-1:0];
                    arlt_pkg::REG_LOAD_GAP:
                        cfg_load_gap    = pwdata[arlt_pkg::PCT_W-1:0];
                    arlt_pkg::REG_MAX_RESTART:
                        cfg_max_restart = pwdata[arlt_pkg::LIMIT_W-1:0];
                    arlt_pkg::REG_HIGH_LIMIT:
                        cfg_high_limit  = pwdata[arlt_pkg::CNT_W-1:0];
                    arlt_pkg::REG_LOW_LIMIT:
                        cfg_low_limit   = pwdata[arlt_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: tb/tb_adaptive_restart_limit_tuner_core.sv
// Testbench top for the restart limit tuner: clock, reset, stimulus, watchdog and verdict.
module tb_adaptive_restart_limit_tuner_core;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic [arlt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [arlt_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b1;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [arlt_pkg::ADDR_W-1:0]    paddr    = '0;
    logic [arlt_pkg::DATA_W-1:0]    pwdata   = '0;
    logic [arlt_pkg::DATA_W-1:0]    prdata;
    logic                           pready;

    int                   fail_count;
    int                   pending;
    int                   quiet_cycles = 0;
    int                   window_len   = 10;
    int                   load_mode    = 0;
    bit                   steady_src   = 1'b0;
    bit                   steady_sink  = 1'b0;
    logic [31:0]          tick_now;

    adaptive_restart_limit_tuner_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    arlt_checker tuner_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always begin
        int stall;
        m_tready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge i_clk);
        stall = steady_sink ? 0 : pick_gap();
        if (stall > 0) begin
            m_tready = 1'b0;
            repeat (stall) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("adaptive_restart_limit_tuner_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(logic op, logic [31:0] now, logic [31:0] start,
                              logic [arlt_pkg::RES_W-1:0] rsv);
        int gap;
        gap = steady_src ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  = {4'd0, rsv, start, now};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_setup(int win, int intv, int peak_load, int gap, int max_rst,
                              int high_lim, int low_lim);
        write_reg(arlt_pkg::REG_WINDOW_TICKS, win);
        write_reg(arlt_pkg::REG_COUNT_INTERVAL, intv);
        write_reg(arlt_pkg::REG_PEAK_LOAD, peak_load);
        write_reg(arlt_pkg::REG_LOAD_GAP, gap);
        write_reg(arlt_pkg::REG_MAX_RESTART, max_rst);
        write_reg(arlt_pkg::REG_HIGH_LIMIT, high_lim);
        write_reg(arlt_pkg::REG_LOW_LIMIT, low_lim);
        window_len  = win;
        steady_src  = ($urandom_range(0, 3) == 0);
        steady_sink = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_traffic(int count);
        int r;
        int dt;
        int busy;
        int span;
        span = window_len / 2 + 2;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 24) == 0) begin
                load_mode = $urandom_range(0, 2);
            end
            r  = $urandom_range(0, 99);
            dt = $urandom_range(0, span);
            if (r < 8) begin
                tick_now += dt;
                send_event(arlt_pkg::OP_IDLE, tick_now, $urandom,
                           4'($urandom_range(0, 15)));
            end else if (r < 12) begin
                tick_now = $urandom;
                send_event(1'($urandom_range(0, 1)), tick_now, $urandom,
                           4'($urandom_range(0, 15)));
            end else if (r < 16) begin
                tick_now += dt;
                send_event(arlt_pkg::OP_BUSY, tick_now, $urandom,
                           4'($urandom_range(0, 15)));
            end else begin
                tick_now += dt;
                case (load_mode)
                    0:       busy = dt * $urandom_range(1, 3) + $urandom_range(0, 2);
                    1:       busy = $urandom_range(0, dt / 4);
                    default: busy = $urandom_range(0, 2 * dt + 1);
                endcase
                send_event(arlt_pkg::OP_BUSY, tick_now, tick_now - busy,
                           4'($urandom_range(0, 15)));
            end
        end
    endtask

    initial begin
        tick_now = 32'hFFFF_F000;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_event(arlt_pkg::OP_IDLE, 32'd100, 32'hFFFF_FFFF, 4'd0);
        send_event(arlt_pkg::OP_BUSY, 32'd105, 32'd100, 4'd15);
        send_event(arlt_pkg::OP_BUSY, 32'd110, 32'd0, 4'd0);
        send_event(arlt_pkg::OP_BUSY, 32'd111, 32'd111, 4'd7);
        send_event(arlt_pkg::OP_BUSY, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 4'd0);
        send_event(arlt_pkg::OP_BUSY, 32'hFFFF_FFFF, 32'd0, 4'd0);
        send_event(arlt_pkg::OP_BUSY, 32'h8000_0079, 32'h8000_0079, 4'd0);
        send_event(arlt_pkg::OP_BUSY, 32'h8000_0078, 32'h8000_0070, 4'd15);
        send_event(arlt_pkg::OP_IDLE, 32'd0, 32'd0, 4'd15);
        send_event(arlt_pkg::OP_BUSY, 32'd5, 32'hFFFF_FFF6, 4'd3);
        send_event(arlt_pkg::OP_BUSY, 32'd11, 32'd10, 4'd0);
        send_event(arlt_pkg::OP_BUSY, 32'd40, 32'd40, 4'd0);
        for (int k = 0; k < 7; k++) begin
            send_event(arlt_pkg::OP_BUSY, 32'd1000 + 25 * k, 32'd970 + 25 * k, 4'(k));
        end
        for (int k = 0; k < 6; k++) begin
            send_event(arlt_pkg::OP_IDLE, 32'd1200 + 25 * k, 32'd0, 4'(15 - k));
        end
        run_traffic(30);
        settle();

        load_setup(10, 1, 110, 20, 255, 2, 2);
        run_traffic(40);
        settle();
        load_setup(10, 1, 255, 0, 40, 1, 1);
        run_traffic(40);
        settle();
        load_setup(10, 20, 110, 20, 5, 6, 15);
        run_traffic(40);
        settle();
        load_setup(1, 1, 0, 0, 255, 1, 1);
        run_traffic(40);
        settle();
        load_setup(65535, 65535, 255, 255, 1, 15, 15);
        run_traffic(40);
        settle();
        load_setup(0, 0, 100, 50, 0, 0, 0);
        run_traffic(40);
        settle();
        for (int p = 0; p < 6; p++) begin
            load_setup($urandom_range(1, 60), $urandom_range(1, 60), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(1, 255), $urandom_range(1, 15),
                       $urandom_range(1, 15));
            run_traffic(40);
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("adaptive_restart_limit_tuner_core verification clean");
        end else begin
            $display("adaptive_restart_limit_tuner_core verification failed");
        end
        $finish;
    end

endmodule

FILE: adaptive_restart_limit_tuner_core.f
src/arlt_pkg.sv
src/arlt_sub_unit.sv
src/arlt_limit_update.sv
src/adaptive_restart_limit_tuner_core.sv
src/arlt_checker.sv
tb/arlt_checker.sv
tb/tb_adaptive_restart_limit_tuner_core.sv
